>>> rtl/core/stereo_tanh_saturator_unit_assert.svh
// assertion macros for the stereo tanh saturator
`ifndef STEREO_TANH_SATURATOR_UNIT_ASSERT_SVH
`define STEREO_TANH_SATURATOR_UNIT_ASSERT_SVH

// plain property, sampled on clk, off while rst is high
`define STSAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define STSAT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STSAT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/stsat_pkg.sv
// shared types, constants and curve generation for the stereo tanh saturator
package stsat_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = SAMPLE_BITS - 1;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_BITS      = 8;
  localparam int ADDR_BITS     = IDX_BITS + 1;
  localparam int TBL_BITS      = FRAC_BITS;

  localparam int LEVEL_BITS    = 11;
  localparam int LEVEL_ONE     = 1024;
  localparam int GAIN_BITS     = 14;
  localparam int MAKEUP_BITS   = 12;
  localparam int CFG_IDX_BITS  = 2;

  // serial multiplier: one multiplier bit per cycle
  localparam int MPLIER_BITS   = 16;
  localparam int ACC_BITS      = 41;

  // table position from |s| * gain
  localparam int GAIN_PROD_BITS = SAMPLE_BITS + GAIN_BITS - 1;
  localparam int IDX_LO         = FRAC_BITS + 12 - IDX_BITS;
  localparam int FR_BITS        = 16;
  localparam int FR_LO          = IDX_LO - FR_BITS;
  localparam int INTERP_SHIFT   = 16;

  // makeup stage
  localparam int SUM_BITS       = SAMPLE_BITS + 1;
  localparam int OUT_PROD_BITS  = SUM_BITS + MAKEUP_BITS;
  localparam int ROUND_SHIFT    = 12;

  localparam logic [CFG_IDX_BITS-1:0] REG_DRIVE_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_LEVEL = 2'd1;

  localparam logic [LEVEL_BITS-1:0] DRIVE_RESET  = 11'd307;
  localparam logic [LEVEL_BITS-1:0] OUTPUT_RESET = 11'd717;

  localparam int          TAYLOR_TERMS = 12;
  localparam logic [63:0] Q32_ONE      = 64'd1 << 32;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_end;
  } stsat_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_result;
    logic signed [SAMPLE_BITS-1:0] right_result;
    logic                          block_end_out;
  } stsat_out_t;

  // one step strobe per lane phase
  typedef struct packed {
    logic load;
    logic mul;
    logic look_a;
    logic look_b;
    logic look_c;
    logic shape;
    logic sum;
    logic magn;
    logic round;
  } stsat_ctrl_t;

  // long division by shift and subtract, only ever called while elaborating the curve
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // curve point k: tanh(4k/entries) as (1-E)/(1+E), E = q^k, q = exp(-8/entries)
  function automatic logic [TBL_BITS-1:0] curve_entry(input int k);
    logic [63:0]  term;
    logic [63:0]  q;
    logic [63:0]  e;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [127:0] prod;
    int           i;
    term = Q32_ONE;
    q    = Q32_ONE;
    for (i = 1; i <= TAYLOR_TERMS; i++) begin
      term = udiv64(term << 3, 64'(TABLE_ENTRIES) * 64'(i));
      if (i[0]) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    e = Q32_ONE;
    for (i = 0; i < k; i++) begin
      prod = 128'(e) * 128'(q) + (128'd1 << 31);
      e    = prod[95:32];
    end
    num = Q32_ONE - e;
    den = Q32_ONE + e;
    return TBL_BITS'(udiv64((num << FRAC_BITS) + (den >> 1), den));
  endfunction

endpackage

>>> rtl/core/stsat_lane.sv
// one channel datapath: serial multiplier, curve lookup, averaging and makeup
module stsat_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  stsat_pkg::stsat_ctrl_t                ctrl,
  input  logic signed [stsat_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [stsat_pkg::GAIN_BITS-1:0]       gain,
  input  logic [stsat_pkg::MAKEUP_BITS-1:0]     makeup,
  output logic signed [stsat_pkg::SAMPLE_BITS-1:0] result
);

  localparam int SB  = stsat_pkg::SAMPLE_BITS;
  localparam int AB  = stsat_pkg::ACC_BITS;
  localparam int MB  = stsat_pkg::MPLIER_BITS;
  localparam int TB  = stsat_pkg::TBL_BITS;
  localparam int NB  = stsat_pkg::ADDR_BITS;
  localparam int XB  = stsat_pkg::SUM_BITS;
  localparam int PB  = stsat_pkg::OUT_PROD_BITS;
  localparam int IHI = stsat_pkg::GAIN_PROD_BITS - 1;
  localparam int ILO = stsat_pkg::IDX_LO;
  localparam int FLO = stsat_pkg::FR_LO;
  localparam int FB  = stsat_pkg::FR_BITS;
  localparam int IS  = stsat_pkg::INTERP_SHIFT;
  localparam int RS  = stsat_pkg::ROUND_SHIFT;

  localparam logic [NB-1:0]   LAST_ADDR = NB'(stsat_pkg::TABLE_ENTRIES);
  localparam logic [PB-1:0]   ROUND_HALF = PB'(1) << (RS - 1);
  localparam logic [XB-1:0]   NEG_LIMIT = XB'(1) << (SB - 1);
  localparam logic [XB-1:0]   POS_LIMIT = (XB'(1) << (SB - 1)) - XB'(1);
  localparam logic [SB-1:0]   SAT_MIN = SB'(1) << (SB - 1);
  localparam logic [SB-1:0]   SAT_MAX = (SB'(1) << (SB - 1)) - SB'(1);

  logic [TB-1:0] curve [0:stsat_pkg::TABLE_ENTRIES];

  for (genvar k = 0; k <= stsat_pkg::TABLE_ENTRIES; k++) begin : g_curve
    localparam logic [TB-1:0] ENTRY = stsat_pkg::curve_entry(k);
    assign curve[k] = ENTRY;
  end

  logic [AB-1:0]  mcand;
  logic [MB-1:0]  mplier;
  logic [AB-1:0]  acc;
  logic           neg;
  logic [NB-1:0]  addr;
  logic [TB-1:0]  base;
  logic [TB-1:0]  y_mag;
  logic [SB-1:0]  prev;
  logic [XB-1:0]  sum_val;
  logic           out_neg;
  logic [XB-1:0]  rnd;

  logic [SB-1:0]           sample_mag;
  logic [IHI-ILO:0]        idx_full;
  logic                    idx_sat;
  logic [SB-1:0]           shaped;
  logic [XB-1:0]           y_ext;
  logic [XB-1:0]           sum_mag;
  logic [PB-1:0]           rounded;

  assign sample_mag = sample[SB-1] ? (~sample + SB'(1)) : sample;
  assign idx_full   = acc[IHI:ILO];
  assign idx_sat    = (idx_full >= (IHI-ILO+1)'(stsat_pkg::TABLE_ENTRIES));
  assign y_ext      = XB'(y_mag);
  assign shaped     = neg ? SB'(~y_ext + XB'(1)) : SB'(y_ext);
  assign sum_mag    = sum_val[XB-1] ? (~sum_val + XB'(1)) : sum_val;
  assign rounded    = acc[PB-1:0] + ROUND_HALF;

  // previous shaped value, the only lane state that survives an item
  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (ctrl.sum) begin
      prev <= shaped;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg    <= sample[SB-1];
      mcand  <= AB'(sample_mag);
      mplier <= MB'(gain);
      acc    <= '0;
    end else if (ctrl.mul) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end else if (ctrl.look_a) begin
      // past the end of the table the end value holds, with no slope
      addr   <= idx_sat ? LAST_ADDR : NB'(idx_full);
      mplier <= idx_sat ? '0 : MB'(acc[FLO +: FB]);
    end else if (ctrl.look_b) begin
      base <= curve[addr];
      addr <= (addr == LAST_ADDR) ? addr : addr + NB'(1);
    end else if (ctrl.look_c) begin
      mcand <= AB'(curve[addr] - base);
      acc   <= '0;
    end else if (ctrl.shape) begin
      y_mag <= base + acc[IS +: TB];
    end else if (ctrl.sum) begin
      sum_val <= neg ? ({prev[SB-1], prev} - y_ext) : ({prev[SB-1], prev} + y_ext);
    end else if (ctrl.magn) begin
      out_neg <= sum_val[XB-1];
      mcand   <= AB'(sum_mag);
      mplier  <= MB'(makeup);
      acc     <= '0;
    end else if (ctrl.round) begin
      rnd <= rounded[RS +: XB];
    end
  end

  // clamp to the sample range, then restore the sign
  always_comb begin
    if (out_neg) begin
      result = (rnd > NEG_LIMIT) ? SAT_MIN : SB'(~rnd + XB'(1));
    end else begin
      result = (rnd > POS_LIMIT) ? SAT_MAX : SB'(rnd);
    end
  end

endmodule

>>> rtl/core/stereo_tanh_saturator_unit.sv
// top level of the stereo tanh saturator
// One stereo pair is taken per beat on the sample channel and one result beat
// leaves on the result channel. Each channel is scaled by 1 + 7*drive_level/1024,
// shaped by a 257-point tanh curve with linear interpolation (held at the end
// value for |x| >= 4), averaged with its previous shaped value and scaled by
// 1.5*output_level/1024, rounding half away from zero and saturating to 24 bits.
// Both channels run side by side in two lanes, each built around one shift-add
// multiplier that takes a multiplier bit per cycle; a pair goes through three
// multiplies plus eight single steps, and the next pair is taken only once the
// last has left the sequencer. sample_stall is high while a pair is in work.
// The finished result sits in an output register, so the next pair is taken
// while it still waits; a new result only waits if that register is still full.
// The config port is always ready; writes must fall while no pair is in work.
// Levels above 1024 are stored as 1024 and writes to unknown indexes are dropped.
`include "stereo_tanh_saturator_unit_assert.svh"

module stereo_tanh_saturator_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample channel
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  stsat_pkg::stsat_in_t                   sample,
  // result channel
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output stsat_pkg::stsat_out_t                  result,
  // config write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [stsat_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [stsat_pkg::LEVEL_BITS-1:0]       cfg_data
);

  localparam int LB       = stsat_pkg::LEVEL_BITS;
  localparam int GB       = stsat_pkg::GAIN_BITS;
  localparam int KB       = stsat_pkg::MAKEUP_BITS;
  localparam int CNT_BITS = $clog2(stsat_pkg::MPLIER_BITS);

  localparam logic [LB-1:0]       LEVEL_MAX = LB'(stsat_pkg::LEVEL_ONE);
  localparam logic [CNT_BITS-1:0] MUL_LAST  = CNT_BITS'(stsat_pkg::MPLIER_BITS - 1);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_MUL_GAIN = 12'b000000000010,
    ST_LOOK_A   = 12'b000000000100,
    ST_LOOK_B   = 12'b000000001000,
    ST_LOOK_C   = 12'b000000010000,
    ST_MUL_FRAC = 12'b000000100000,
    ST_SHAPE    = 12'b000001000000,
    ST_SUM      = 12'b000010000000,
    ST_MAGN     = 12'b000100000000,
    ST_MUL_OUT  = 12'b001000000000,
    ST_ROUND    = 12'b010000000000,
    ST_DONE     = 12'b100000000000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [CNT_BITS-1:0]    step_cnt;
  logic [CNT_BITS-1:0]    step_cnt_next;
  logic [LB-1:0]          drive_level;
  logic [LB-1:0]          output_level;
  logic                   block_end;

  logic                   sample_take;
  logic                   result_take;
  logic                   out_free;
  logic                   mul_phase;
  logic                   mul_last;
  logic [LB-1:0]          cfg_level;
  logic [GB-1:0]          gain;
  logic [KB-1:0]          makeup;
  stsat_pkg::stsat_ctrl_t ctrl;
  logic signed [stsat_pkg::SAMPLE_BITS-1:0] left_result;
  logic signed [stsat_pkg::SAMPLE_BITS-1:0] right_result;

  // handshakes
  assign sample_stall = (state != ST_IDLE);
  assign sample_take  = sample_valid && !sample_stall;
  assign result_take  = result_valid && !result_stall;
  assign out_free     = !result_valid || !result_stall;
  assign cfg_ready    = 1'b1;

  // level registers, clamped to one on the way in
  assign cfg_level = (cfg_data > LEVEL_MAX) ? LEVEL_MAX : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_level  <= stsat_pkg::DRIVE_RESET;
      output_level <= stsat_pkg::OUTPUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stsat_pkg::REG_DRIVE_LEVEL:  drive_level  <= cfg_level;
        stsat_pkg::REG_OUTPUT_LEVEL: output_level <= cfg_level;
        default: ;
      endcase
    end
  end

  // input gain 1024 + 7*drive, makeup 3*output (the /4096 comes at rounding)
  assign gain   = GB'(stsat_pkg::LEVEL_ONE) + (GB'(drive_level) << 3) - GB'(drive_level);
  assign makeup = (KB'(output_level) << 1) + KB'(output_level);

  // sequencer
  assign mul_phase = (state == ST_MUL_GAIN) || (state == ST_MUL_FRAC) ||
                     (state == ST_MUL_OUT);
  assign mul_last  = (step_cnt == MUL_LAST);

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    if (mul_phase) begin
      step_cnt_next = mul_last ? '0 : step_cnt + CNT_BITS'(1);
    end
    case (state)
      ST_IDLE:     if (sample_take) state_next = ST_MUL_GAIN;
      ST_MUL_GAIN: if (mul_last) state_next = ST_LOOK_A;
      ST_LOOK_A:   state_next = ST_LOOK_B;
      ST_LOOK_B:   state_next = ST_LOOK_C;
      ST_LOOK_C:   state_next = ST_MUL_FRAC;
      ST_MUL_FRAC: if (mul_last) state_next = ST_SHAPE;
      ST_SHAPE:    state_next = ST_SUM;
      ST_SUM:      state_next = ST_MAGN;
      ST_MAGN:     state_next = ST_MUL_OUT;
      ST_MUL_OUT:  if (mul_last) state_next = ST_ROUND;
      ST_ROUND:    state_next = ST_DONE;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // lane strobes
  assign ctrl.load   = sample_take;
  assign ctrl.mul    = mul_phase;
  assign ctrl.look_a = (state == ST_LOOK_A);
  assign ctrl.look_b = (state == ST_LOOK_B);
  assign ctrl.look_c = (state == ST_LOOK_C);
  assign ctrl.shape  = (state == ST_SHAPE);
  assign ctrl.sum    = (state == ST_SUM);
  assign ctrl.magn   = (state == ST_MAGN);
  assign ctrl.round  = (state == ST_ROUND);

  always_ff @(posedge clk) begin
    if (sample_take) begin
      block_end <= sample.block_end;
    end
  end

  stsat_lane u_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (sample.left_sample),
    .gain   (gain),
    .makeup (makeup),
    .result (left_result)
  );

  stsat_lane u_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (sample.right_sample),
    .gain   (gain),
    .makeup (makeup),
    .result (right_result)
  );

  // output register, loaded once the finished pair finds it free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      result.left_result   <= left_result;
      result.right_result  <= right_result;
      result.block_end_out <= block_end;
    end
  end

  // checks
  `STSAT_ASSERT(a_level_range, (drive_level <= LEVEL_MAX) && (output_level <= LEVEL_MAX), "level register above one")
  `STSAT_ASSERT_IMP(a_cnt_rest, !mul_phase, step_cnt == '0, "step count left running outside a multiply")
  `STSAT_ASSERT_NXT(a_done_load, (state == ST_DONE) && out_free, result_valid && (state == ST_IDLE), "finished pair not handed to the output")
  `STSAT_ASSERT_IMP(a_valid_source, $rose(result_valid), $past(state) == ST_DONE, "result raised without a finished pair")

endmodule

>>> dv/tb.sv
// self-checking testbench for the stereo tanh saturator unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stsat_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 9;
  // settle time that covers one pair in work plus margin
  localparam int SETTLE_CYCLES   = 80;
  // long receiver hold-off so the block fills and stalls its sample side
  localparam int HOLD_CYCLES     = 800;
  // cycles with no beat on any channel before the run is called hung
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int RANDOM_PHASES   = 8;
  localparam int PAIRS_PER_PHASE = 225;

  // config indexes that map to no register
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX  = {1'b0, {FRAC_BITS{1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_HALF = 24'sh400000;

  // dut ports, all inputs known from time zero
  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  stsat_in_t               sample       = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  stsat_out_t              result;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
  logic [LEVEL_BITS-1:0]   cfg_data     = '0;

  // predictor state: curve, level registers and last shaped value per channel
  logic [TBL_BITS-1:0]          tanh_points [0:TABLE_ENTRIES];
  logic [LEVEL_BITS-1:0]        drive_level_q     = DRIVE_RESET;
  logic [LEVEL_BITS-1:0]        output_level_q    = OUTPUT_RESET;
  logic signed [SAMPLE_BITS:0]  last_left_shaped  = '0;
  logic signed [SAMPLE_BITS:0]  last_right_shaped = '0;

  stsat_in_t  pending_pairs[$];      // pairs waiting for the driver
  stsat_out_t predicted_outputs[$];  // expected result beats, oldest first
  stsat_out_t oldest_prediction;

  int pairs_queued  = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_asks     = 0;
  int hold_given    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  stereo_tanh_saturator_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // tanh(4k/entries) = (1-E)/(1+E) with E = q^k; q = exp(-8/entries) as a
  // truncated taylor sum in q.32, each power step rounded back to q.32
  function automatic void build_tanh_points();
    logic [63:0]  step_term;
    logic [63:0]  decay;
    logic [63:0]  power;
    logic [63:0]  diff;
    logic [63:0]  total;
    logic [127:0] wide;
    step_term = 64'd1 << 32;
    decay     = 64'd1 << 32;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      step_term = (step_term * 64'd8) / (64'(TABLE_ENTRIES) * 64'(n));
      if (n % 2 == 1) begin
        decay = decay - step_term;
      end else begin
        decay = decay + step_term;
      end
    end
    power = 64'd1 << 32;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      diff           = (64'd1 << 32) - power;
      total          = (64'd1 << 32) + power;
      tanh_points[k] = TBL_BITS'(((diff << FRAC_BITS) + total / 2) / total);
      wide           = 128'(power) * 128'(decay) + (128'd1 << 31);
      power          = wide[95:32];
    end
  endfunction

  // odd soft clip: interpolate on the magnitude, put the sign back at the end
  function automatic logic signed [SAMPLE_BITS:0] soft_clip(
    input logic signed [SAMPLE_BITS-1:0] s,
    input logic [GAIN_BITS-1:0]          gain
  );
    logic [SAMPLE_BITS-1:0] mag;
    logic [63:0]            pos;
    logic [63:0]            lo;
    logic [63:0]            hi;
    logic [63:0]            y;
    logic [15:0]            frac;
    int                     idx;
    mag  = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;  // most negative gives 2^23 exactly
    pos  = 64'(mag) * 64'(gain) * 64'(TABLE_ENTRIES);
    frac = pos[FRAC_BITS-4 +: 16];
    if ((pos >> (FRAC_BITS + 12)) >= 64'(TABLE_ENTRIES)) begin
      // at or beyond |x| = 4 the curve holds its end value
      y = 64'(tanh_points[TABLE_ENTRIES]);
    end else begin
      idx = int'(pos >> (FRAC_BITS + 12));
      lo  = 64'(tanh_points[idx]);
      hi  = 64'(tanh_points[idx + 1]);
      y   = lo + (((hi - lo) * 64'(frac)) >> 16);
    end
    if (s[SAMPLE_BITS-1]) begin
      return -$signed({1'b0, y[SAMPLE_BITS-1:0]});
    end
    return $signed({1'b0, y[SAMPLE_BITS-1:0]});
  endfunction

  // makeup 3*level/4096 on the sum, round half away from zero, then clamp to 24 bits
  function automatic logic signed [SAMPLE_BITS-1:0] makeup_and_clamp(
    input logic signed [SAMPLE_BITS+1:0] total
  );
    logic [63:0] mag;
    logic [63:0] r;
    mag = (total < 0) ? 64'(-total) : 64'(total);
    r   = (mag * 64'(output_level_q) * 64'd3 + 64'd2048) >> ROUND_SHIFT;
    if (total < 0) begin
      return (r > (64'd1 << FRAC_BITS)) ? S_MIN : SAMPLE_BITS'(-r);
    end
    return (r > 64'(S_MAX)) ? S_MAX : SAMPLE_BITS'(r);
  endfunction

  // levels above unity behave as unity
  function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [LEVEL_BITS-1:0] v);
    return (v > LEVEL_ONE) ? LEVEL_BITS'(LEVEL_ONE) : v;
  endfunction

  task automatic predict_saturated_pair(input stsat_in_t pair);
    logic [GAIN_BITS-1:0]        gain;
    logic signed [SAMPLE_BITS:0] sl;
    logic signed [SAMPLE_BITS:0] sr;
    stsat_out_t                  o;
    gain            = GAIN_BITS'(LEVEL_ONE + 7 * drive_level_q);
    sl              = soft_clip(pair.left_sample, gain);
    sr              = soft_clip(pair.right_sample, gain);
    o.left_result   = makeup_and_clamp(sl + last_left_shaped);
    o.right_result  = makeup_and_clamp(sr + last_right_shaped);
    o.block_end_out = pair.block_end;
    last_left_shaped  = sl;
    last_right_shaped = sr;
    predicted_outputs.push_back(o);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_pair(
    input logic signed [SAMPLE_BITS-1:0] l,
    input logic signed [SAMPLE_BITS-1:0] r,
    input logic                          last
  );
    pending_pairs.push_back('{l, r, last});
    pairs_queued++;
  endtask

  // mix of full-range noise, small magnitudes and corner values
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    logic [SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 3))
      1: begin
        v = SAMPLE_BITS'($urandom) >> $urandom_range(1, FRAC_BITS);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      2: begin
        case ($urandom_range(0, 4))
          0:       v = S_MAX;
          1:       v = S_MIN;
          2:       v = '0;
          3:       v = '1;
          default: v = SAMPLE_BITS'(1);
        endcase
      end
      default: v = SAMPLE_BITS'($urandom);
    endcase
    return v;
  endfunction

  // one register write; cfg_valid stays up so back-to-back writes need one nba
  task automatic write_level(
    input logic [CFG_IDX_BITS-1:0] idx,
    input logic [LEVEL_BITS-1:0]   value
  );
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DRIVE_LEVEL:  drive_level_q  = clamp_level(value);
      REG_OUTPUT_LEVEL: output_level_q = clamp_level(value);
      default: ;  // spare indexes hold nothing
    endcase
  endtask

  // both levels, then a write to a spare index that must change nothing
  task automatic set_levels(
    input logic [LEVEL_BITS-1:0] drive,
    input logic [LEVEL_BITS-1:0] makeup
  );
    write_level(REG_DRIVE_LEVEL, drive);
    write_level(REG_OUTPUT_LEVEL, makeup);
    write_level(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                LEVEL_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // every queued pair has come back, then let the pipe settle
  task automatic wait_for_idle();
    do @(posedge clk); while (results_seen < pairs_queued);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sample driver: predicts on each accepted beat, holds a stalled payload
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        predict_saturated_pair(sample);
      end
      if (sample_valid && sample_stall) begin
        // beat still offered, payload unchanged
      end else if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        sample       <= pending_pairs.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: field by field against the oldest prediction, plus stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (predicted_outputs.size() == 0) begin
          mismatches++;
          $error("result beat with no pair waiting");
        end else begin
          oldest_prediction = predicted_outputs.pop_front();
          if (result.left_result !== oldest_prediction.left_result) begin
            mismatches++;
            $error("left_result: expected %0d, got %0d",
                   oldest_prediction.left_result, result.left_result);
          end
          if (result.right_result !== oldest_prediction.right_result) begin
            mismatches++;
            $error("right_result: expected %0d, got %0d",
                   oldest_prediction.right_result, result.right_result);
          end
          if (result.block_end_out !== oldest_prediction.block_end_out) begin
            mismatches++;
            $error("block_end_out: expected %0d, got %0d",
                   oldest_prediction.block_end_out, result.block_end_out);
          end
        end
      end
      // hold-off requested: stall for a long counted stretch
      if (hold_asks != hold_given) begin
        hold_given   <= hold_given + 1;
        hold_left    <= HOLD_CYCLES;
        result_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < snk_stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    build_tanh_points();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset levels: sample extremes, sign pairs and block marks
    push_pair('0, '0, 1'b0);
    push_pair(S_MAX, S_MIN, 1'b0);
    push_pair(S_MIN, S_MAX, 1'b1);
    push_pair(S_MIN, S_MIN, 1'b0);
    push_pair(S_MAX, S_MAX, 1'b0);
    push_pair(24'sd1, -24'sd1, 1'b0);
    push_pair(-24'sd1, 24'sd1, 1'b1);
    push_pair(S_HALF, -S_HALF, 1'b0);
    push_pair(24'sh012345, -24'sh00abcd, 1'b0);
    wait_for_idle();

    // full drive and makeup: past the table end and into output saturation
    set_levels(LEVEL_BITS'(LEVEL_ONE), LEVEL_BITS'(LEVEL_ONE));
    push_pair(S_MAX, S_MAX, 1'b0);
    push_pair(S_MAX, S_MAX, 1'b0);
    push_pair(S_MIN, S_MIN, 1'b0);
    push_pair(S_MIN, S_MIN, 1'b1);
    push_pair(S_HALF, -S_HALF, 1'b0);          // exactly |x| = 4
    push_pair(24'sh3fffff, -24'sh3fffff, 1'b0); // just short of the table end
    push_pair('0, '0, 1'b1);
    wait_for_idle();

    // levels written above unity act as unity
    set_levels('1, '1);
    push_pair(S_MAX, S_MIN, 1'b0);
    push_pair(S_MIN, S_MAX, 1'b1);
    wait_for_idle();

    // both levels at zero: unity gain in, silence out
    set_levels('0, '0);
    push_pair(S_MAX, S_MIN, 1'b0);
    push_pair(24'sh00f000, -24'sh00f000, 1'b1);
    wait_for_idle();

    // random phases, each with its own levels and idling pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1: set_levels('0, LEVEL_BITS'(LEVEL_ONE));
        2: set_levels(LEVEL_BITS'(LEVEL_ONE), LEVEL_BITS'(LEVEL_ONE));
        4: set_levels('1, '0);
        6: set_levels('0, '0);
        7: set_levels(LEVEL_BITS'($urandom), LEVEL_BITS'($urandom));
        default: set_levels(LEVEL_BITS'($urandom_range(0, LEVEL_ONE)),
                            LEVEL_BITS'($urandom_range(0, LEVEL_ONE)));
      endcase
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
        default: begin src_idle_pct = 13; snk_stall_pct = 13; end
      endcase
      // first phase: receiver holds off while the sender keeps offering
      if (p == 0) begin
        hold_asks++;
      end
      for (int i = 0; i < PAIRS_PER_PHASE; i++) begin
        push_pair(random_sample(), random_sample(), $urandom_range(0, 7) == 0);
      end
      wait_for_idle();
    end

    if (mismatches == 0 && predicted_outputs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/stsat_pkg.sv
rtl/core/stsat_lane.sv
rtl/core/stereo_tanh_saturator_unit.sv
dv/tb.sv
